[hdl/psnt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psnt_pkg
// Shared sizes, codes, link types and name helper for the sorted name table.
// ---------------------------------------------------------------------------
package psnt_pkg;

	localparam int ENTRIES    = 32;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int NAME_BYTES = 19;
	localparam int NAME_W     = 8 * NAME_BYTES;
	localparam int PRI_W      = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef logic [NAME_W-1:0] name_t;

	typedef struct packed {
		logic                    valid;
		logic                    ins;
		name_t                   name;
		logic signed [PRI_W-1:0] pri;
	} link_t;

	typedef struct packed {
		logic                    seen;
		logic signed [PRI_W-1:0] pri;
	} srch_t;

	typedef struct packed {
		logic                    calc;
		logic                    commit;
		logic [1:0]              op;
		name_t                   name;
		logic signed [PRI_W-1:0] pri;
	} ctl_t;

	// clear every byte after the first zero byte
	function automatic name_t tidy_name(name_t raw);
		name_t res;
		logic  ended;
		res   = '0;
		ended = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			res[8*k +: 8] = ended ? 8'h00 : raw[8*k +: 8];
			if (raw[8*k +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

[hdl/psnt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psnt request and response channels
// Valid/ready channels carrying one table command word and one result word.
// ---------------------------------------------------------------------------
interface psnt_req_if;
	import psnt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic [63:0]             name_part0;
	logic [63:0]             name_part1;
	logic [23:0]             name_part2;
	logic signed [PRI_W-1:0] new_priority;

	modport source (
		output valid, action, name_part0, name_part1, name_part2, new_priority,
		input  ready
	);
	modport sink (
		input  valid, action, name_part0, name_part1, name_part2, new_priority,
		output ready
	);
endinterface

interface psnt_rsp_if;
	import psnt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [PRI_W-1:0] found_priority;
	logic [5:0]              item_count;

	modport source (
		output valid, status, found_priority, item_count,
		input  ready
	);
	modport sink (
		input  valid, status, found_priority, item_count,
		output ready
	);
endinterface
`default_nettype wire

[hdl/psnt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// psnt_cell
// One table slot: compares against the broadcast word, then shifts toward
// either neighbor or loads the new item on commit.
// ---------------------------------------------------------------------------
module psnt_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  psnt_pkg::ctl_t        ctl,
	input  psnt_pkg::link_t       prev,
	input  psnt_pkg::link_t       next,
	output psnt_pkg::link_t       own,
	input  psnt_pkg::srch_t       srch_in,
	output psnt_pkg::srch_t       srch_out
);
	import psnt_pkg::*;

	logic                    valid_q;
	logic                    match_q;
	logic                    ins_q;
	name_t                   name_q;
	logic signed [PRI_W-1:0] pri_q;

	logic                    take_new;
	logic                    take_prev;
	logic                    take_next;
	logic                    seen_out;

	assign seen_out  = srch_in.seen || match_q;
	assign take_new  = ctl.commit && (ctl.op == OP_INSERT) && ins_q && !prev.ins;
	assign take_prev = ctl.commit && (ctl.op == OP_INSERT) && prev.ins;
	assign take_next = ctl.commit && (ctl.op == OP_DELETE) && seen_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			ins_q   <= 1'b0;
		end else begin
			if (ctl.calc) begin
				match_q <= valid_q && (name_q == ctl.name);
				ins_q   <= !valid_q || ($signed(pri_q) <= $signed(ctl.pri));
			end
			if (take_new || take_prev) begin
				valid_q <= valid_q || prev.valid;
			end else if (take_next) begin
				valid_q <= next.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			name_q <= ctl.name;
			pri_q  <= ctl.pri;
		end else if (take_prev) begin
			name_q <= prev.name;
			pri_q  <= prev.pri;
		end else if (take_next) begin
			name_q <= next.name;
			pri_q  <= next.pri;
		end
	end

	assign own.valid = valid_q;
	assign own.ins   = ins_q;
	assign own.name  = name_q;
	assign own.pri   = pri_q;

	assign srch_out.seen = seen_out;
	assign srch_out.pri  = srch_in.seen ? srch_in.pri : (match_q ? pri_q : '0);

endmodule
`default_nettype wire

[hdl/priority_sorted_name_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// priority_sorted_name_table
// Named items kept in descending priority order with insert, delete, search.
// ---------------------------------------------------------------------------
// Each command word passes these steps before its result sits in the output
// register: one registers the tidied name, one in which every cell compares
// that name and priority with its own slot, and one in which the cells shift
// toward a neighbor and the result is formed from the search chain. A new
// word is accepted only once the previous one has left the commit step, so
// the block does not take a new command while one is in flight; a result
// left waiting at the output holds only the commit step of the following
// word. The search chain runs through all cells in the commit cycle.
module priority_sorted_name_table (
	input  wire        clk,
	input  wire        arst_n,
	psnt_req_if.sink   req,
	psnt_rsp_if.source rsp
);
	import psnt_pkg::*;

	logic                    accept;
	logic                    adv;
	logic                    vld_s1;
	logic                    vld_s2;
	logic [1:0]              op_s1;
	name_t                   name_s1;
	logic signed [PRI_W-1:0] pri_s1;
	logic [CNT_W-1:0]        count_q;
	logic                    out_vld_q;
	logic [1:0]              status_q;
	logic signed [PRI_W-1:0] found_q;
	logic [5:0]              item_count_q;

	logic                    full;
	logic [CNT_W-1:0]        count_nxt;
	logic [1:0]              status_nxt;
	logic signed [PRI_W-1:0] found_nxt;
	ctl_t                    ctl;
	link_t                   own   [ENTRIES];
	link_t                   prv   [ENTRIES];
	link_t                   nxt   [ENTRIES];
	srch_t                   sch   [ENTRIES+1];
	logic [ENTRIES-1:0]      valid_vec;

	assign req.ready = !vld_s1 && !vld_s2;
	assign accept    = req.valid && req.ready;
	assign adv       = vld_s2 && (!out_vld_q || rsp.ready);
	assign full      = (count_q == CNT_W'(ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			count_q   <= '0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1 || (vld_s2 && !adv);
			if (adv) begin
				out_vld_q <= 1'b1;
				count_q   <= count_nxt;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.action;
			name_s1 <= tidy_name({req.name_part2, req.name_part1, req.name_part0});
			pri_s1  <= req.new_priority;
		end
		if (adv) begin
			status_q     <= status_nxt;
			found_q      <= found_nxt;
			item_count_q <= 6'(count_nxt);
		end
	end

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		found_nxt  = '0;
		unique case (op_s1)
			OP_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (sch[ENTRIES].seen) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			OP_SEARCH: begin
				if (sch[ENTRIES].seen) begin
					found_nxt = sch[ENTRIES].pri;
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	assign ctl.calc   = vld_s1;
	assign ctl.commit = adv && (((op_s1 == OP_INSERT) && !full) || (op_s1 == OP_DELETE));
	assign ctl.op     = op_s1;
	assign ctl.name   = name_s1;
	assign ctl.pri    = pri_s1;

	assign sch[0].seen = 1'b0;
	assign sch[0].pri  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prv[i].valid = 1'b1;
			assign prv[i].ins   = 1'b0;
			assign prv[i].name  = '0;
			assign prv[i].pri   = '0;
		end else begin : g_mid
			assign prv[i] = own[i-1];
		end
		if (i == ENTRIES - 1) begin : g_tail
			assign nxt[i].valid = 1'b0;
			assign nxt[i].ins   = 1'b0;
			assign nxt[i].name  = '0;
			assign nxt[i].pri   = '0;
		end else begin : g_body
			assign nxt[i] = own[i+1];
		end
		assign valid_vec[i] = own[i].valid;

		psnt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev     (prv[i]),
			.next     (nxt[i]),
			.own      (own[i]),
			.srch_in  (sch[i]),
			.srch_out (sch[i+1])
		);
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = status_q;
	assign rsp.found_priority = found_q;
	assign rsp.item_count     = item_count_q;

`ifndef SYNTHESIS
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("stored items not packed at low slots");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("item counter disagrees with slot valid bits");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_s1 && vld_s2))
		else $error("two words in flight");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (status_nxt == ST_FULL) |=> (item_count_q == 6'(ENTRIES)))
		else $error("dropped insert reported wrong count");

	a_commit_pair: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> vld_s2)
		else $error("compare step not followed by commit step");
`endif

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: priority sorted name table
// Drives insert, delete, search and unused command words into the table and
// checks every result word against the values listed for typed directed words
// or against a table kept here in priority order. A short directed list covers
// empty-table cases, full-length names, priority extremes, tied priorities and
// name tidying; random words then fill and drain the table under sender gaps,
// receiver stalls, a long receiver hold and a drain pause.
module tb;
	import psnt_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int HOLD_LEN    = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 12;
	localparam int PHASE_ITEMS = 100;
	localparam int POOL_SIZE   = 16;
	localparam int DIR_N       = 22;

	localparam logic signed [PRI_W-1:0] PRI_MAX = 32'sh7fffffff;
	localparam logic signed [PRI_W-1:0] PRI_MIN = 32'sh80000000;

	localparam name_t NM_A           = name_t'(8'h41);
	localparam name_t NM_B           = name_t'(16'h4242);
	localparam name_t NM_C           = name_t'(8'h43);
	localparam name_t NM_C_DIRTY     = {8'hA5, 96'h0, 48'hDEADBEEF0043};
	localparam name_t NM_FULL        = {NAME_W{1'b1}};
	localparam name_t NM_EMPTY       = '0;
	localparam name_t NM_EMPTY_DIRTY = {128'h0, 24'h55AA00};

	typedef struct packed {
		logic [1:0]              status;
		logic signed [PRI_W-1:0] found;
		logic [5:0]              count;
	} tbl_result_t;

	typedef struct packed {
		logic [1:0]              act;
		name_t                   nm;
		logic signed [PRI_W-1:0] pri;
		logic                    typed;
		logic [1:0]              st;
		logic signed [PRI_W-1:0] fp;
		logic [5:0]              cnt;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{OP_SEARCH, NM_A,           32'sd0,  1'b1, ST_NOT_FOUND, 32'sd0,  6'd0},
		'{OP_DELETE, NM_A,           32'sd0,  1'b1, ST_NOT_FOUND, 32'sd0,  6'd0},
		'{OP_NOP,    NM_FULL,        PRI_MAX, 1'b1, ST_OK,        32'sd0,  6'd0},
		'{OP_INSERT, NM_A,           PRI_MAX, 1'b1, ST_OK,        32'sd0,  6'd1},
		'{OP_INSERT, NM_B,           PRI_MIN, 1'b1, ST_OK,        32'sd0,  6'd2},
		'{OP_SEARCH, NM_A,           32'sd0,  1'b1, ST_OK,        PRI_MAX, 6'd2},
		'{OP_SEARCH, NM_B,           32'sd0,  1'b1, ST_OK,        PRI_MIN, 6'd2},
		'{OP_INSERT, NM_C_DIRTY,     32'sd5,  1'b1, ST_OK,        32'sd0,  6'd3},
		'{OP_INSERT, NM_FULL,        32'sd5,  1'b1, ST_OK,        32'sd0,  6'd4},
		'{OP_INSERT, NM_EMPTY_DIRTY, -32'sd1, 1'b1, ST_OK,        32'sd0,  6'd5},
		'{OP_SEARCH, NM_C,           PRI_MIN, 1'b1, ST_OK,        32'sd5,  6'd5},
		'{OP_SEARCH, NM_EMPTY,       32'sd0,  1'b1, ST_OK,        -32'sd1, 6'd5},
		'{OP_DELETE, NM_C,           32'sd0,  1'b1, ST_OK,        32'sd0,  6'd4},
		'{OP_SEARCH, NM_C_DIRTY,     32'sd0,  1'b1, ST_NOT_FOUND, 32'sd0,  6'd4},
		'{OP_SEARCH, NM_FULL,        32'sd0,  1'b0, ST_OK,        32'sd0,  6'd0},
		'{OP_INSERT, NM_A,           32'sd3,  1'b1, ST_OK,        32'sd0,  6'd5},
		'{OP_DELETE, NM_A,           32'sd0,  1'b1, ST_OK,        32'sd0,  6'd4},
		'{OP_SEARCH, NM_A,           32'sd0,  1'b0, ST_OK,        32'sd0,  6'd0},
		'{OP_NOP,    NM_B,           PRI_MIN, 1'b1, ST_OK,        32'sd0,  6'd4},
		'{OP_DELETE, NM_EMPTY,       32'sd0,  1'b1, ST_OK,        32'sd0,  6'd3},
		'{OP_DELETE, NM_B,           32'sd0,  1'b1, ST_OK,        32'sd0,  6'd2},
		'{OP_SEARCH, NM_B,           32'sd0,  1'b1, ST_NOT_FOUND, 32'sd0,  6'd2}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	psnt_req_if req ();
	psnt_rsp_if rsp ();

	priority_sorted_name_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// table copy, highest priority at slot 0
	name_t                   tbl_name [ENTRIES];
	logic signed [PRI_W-1:0] tbl_pri  [ENTRIES];
	int                      tbl_cnt = 0;

	tbl_result_t due_results [$];
	tbl_result_t due_head;
	name_t       name_pool [POOL_SIZE];
	int          mismatches     = 0;
	int          cycle_cnt      = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	bit          hold_go        = 1'b0;
	int          hold_cnt       = 0;

	function automatic int name_len(name_t nm);
		int len;
		len = 0;
		while (len < NAME_BYTES && nm[8*len +: 8] != 8'h00) begin
			len++;
		end
		return len;
	endfunction

	function automatic name_t clean_name(name_t raw);
		int    len;
		name_t keep;
		len  = name_len(raw);
		keep = (len == NAME_BYTES) ? {NAME_W{1'b1}} : ((name_t'(1) << (8 * len)) - name_t'(1));
		return raw & keep;
	endfunction

	function automatic int find_slot(name_t nm);
		int hit;
		hit = -1;
		for (int i = 0; i < tbl_cnt; i++) begin
			if (hit < 0 && tbl_name[i] == nm) begin
				hit = i;
			end
		end
		return hit;
	endfunction

	function automatic tbl_result_t table_apply(logic [1:0] act, name_t raw,
			logic signed [PRI_W-1:0] pri);
		tbl_result_t res;
		name_t       nm;
		int          pos;
		res = '{ST_OK, 32'sd0, 6'd0};
		nm  = clean_name(raw);
		case (act)
			OP_INSERT: begin
				if (tbl_cnt >= ENTRIES) begin
					res.status = ST_FULL;
				end else begin
					pos = tbl_cnt;
					for (int i = 0; i < tbl_cnt; i++) begin
						if (pos == tbl_cnt && tbl_pri[i] <= pri) begin
							pos = i;
						end
					end
					for (int i = tbl_cnt; i > pos; i--) begin
						tbl_name[i] = tbl_name[i-1];
						tbl_pri[i]  = tbl_pri[i-1];
					end
					tbl_name[pos] = nm;
					tbl_pri[pos]  = pri;
					tbl_cnt++;
				end
			end
			OP_DELETE: begin
				pos = find_slot(nm);
				if (pos < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < tbl_cnt; i++) begin
						tbl_name[i] = tbl_name[i+1];
						tbl_pri[i]  = tbl_pri[i+1];
					end
					tbl_cnt--;
				end
			end
			OP_SEARCH: begin
				pos = find_slot(nm);
				if (pos < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.found = tbl_pri[pos];
				end
			end
			default: begin
			end
		endcase
		res.count = 6'(tbl_cnt);
		return res;
	endfunction

	function automatic name_t rand_name();
		return name_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
	endfunction

	// random bytes after the terminator, which the table must ignore
	function automatic name_t soil_name(name_t nm);
		name_t res;
		res = nm;
		for (int k = name_len(nm) + 1; k < NAME_BYTES; k++) begin
			res[8*k +: 8] = 8'($urandom);
		end
		return res;
	endfunction

	function automatic name_t pick_name(bit stored);
		name_t nm;
		if (stored && tbl_cnt > 0) begin
			nm = tbl_name[$urandom_range(tbl_cnt - 1)];
		end else begin
			nm = name_pool[$urandom_range(POOL_SIZE - 1)];
		end
		if ($urandom_range(3) == 0) begin
			nm = soil_name(nm);
		end
		return nm;
	endfunction

	function automatic logic signed [PRI_W-1:0] rand_pri();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return PRI_MAX;
		end else if (r == 1) begin
			return PRI_MIN;
		end else if (r < 6) begin
			return PRI_W'($signed($urandom_range(6)) - 3);
		end
		return PRI_W'($urandom);
	endfunction

	// one command word per call, predicted once accepted
	task automatic send_word(input logic [1:0] act, input name_t nm,
			input logic signed [PRI_W-1:0] pri, input bit typed,
			input tbl_result_t typed_res, output tbl_result_t got);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req.valid        <= 1'b1;
		req.action       <= act;
		req.name_part0   <= nm[63:0];
		req.name_part1   <= nm[127:64];
		req.name_part2   <= nm[151:128];
		req.new_priority <= pri;
		do @(posedge clk); while (req.ready !== 1'b1);
		got = table_apply(act, nm, pri);
		due_results.push_back(typed ? typed_res : got);
	endtask

	task automatic pause_until_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				due_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: status %0d found %0d count %0d",
						rsp.status, rsp.found_priority, rsp.item_count);
				end
			end else begin
				due_head = due_results.pop_front();
				if (rsp.status !== due_head.status || rsp.found_priority !== due_head.found ||
						rsp.item_count !== due_head.count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: want status %0d found %0d count %0d, got %0d %0d %0d",
							due_head.status, due_head.found, due_head.count,
							rsp.status, rsp.found_priority, rsp.item_count);
					end
				end
			end
		end
		if (hold_go && hold_cnt < HOLD_LEN) begin
			rsp.ready <= 1'b0;
			hold_cnt++;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		tbl_result_t got;
		tbl_result_t typed_res;
		dir_row_t    row;
		logic [1:0]  act;
		name_t       nm;
		logic signed [PRI_W-1:0] pri;
		bit          growing;
		int          full_hits;
		int          empty_hits;
		int          done;
		int          r;

		req.valid        = 1'b0;
		req.action       = OP_INSERT;
		req.name_part0   = '0;
		req.name_part1   = '0;
		req.name_part2   = '0;
		req.new_priority = '0;
		rsp.ready        = 1'b0;

		for (int p = 0; p < POOL_SIZE; p++) begin
			name_pool[p] = '0;
			for (int k = 0; k < ((p == 0) ? NAME_BYTES : $urandom_range(NAME_BYTES)); k++) begin
				name_pool[p][8*k +: 8] = 8'($urandom_range(255, 1));
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			row       = DIR_ROWS[i];
			typed_res = '{row.st, row.fp, row.cnt};
			send_word(row.act, row.nm, row.pri, row.typed, typed_res, got);
		end

		growing    = 1'b1;
		full_hits  = 0;
		empty_hits = 0;
		typed_res  = '0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				3: begin send_idle_pct = 22; recv_stall_pct = 22; end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_go        = 1'b1;
				end
			endcase
			done = 0;
			while (done < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 2) begin
					act = OP_NOP;
					nm  = rand_name();
					pri = PRI_W'($urandom);
				end else if (r < 7) begin
					act = 2'($urandom_range(3));
					nm  = rand_name();
					pri = PRI_W'($urandom);
				end else begin
					r   = $urandom_range(99);
					pri = PRI_W'($urandom);
					if (r < (growing ? 70 : 15)) begin
						act = OP_INSERT;
						nm  = pick_name(1'b0);
						pri = rand_pri();
					end else if (r < (growing ? 82 : 80)) begin
						act = OP_DELETE;
						nm  = pick_name($urandom_range(99) < 85);
					end else begin
						act = OP_SEARCH;
						nm  = pick_name($urandom_range(99) < 70);
					end
				end
				send_word(act, nm, pri, 1'b0, typed_res, got);
				if (act != OP_NOP) begin
					done++;
				end
				// swing between a full and an empty table
				if (growing && got.status == ST_FULL) begin
					full_hits++;
					if (full_hits >= 3) begin
						growing   = 1'b0;
						full_hits = 0;
					end
				end else if (!growing && tbl_cnt == 0 && got.status == ST_NOT_FOUND) begin
					empty_hits++;
					if (empty_hits >= 3) begin
						growing    = 1'b1;
						empty_hits = 0;
					end
				end
				if (done == PHASE_ITEMS / 2 && act != OP_NOP) begin
					pause_until_drained();
				end
			end
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		req.valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
hdl/psnt_pkg.sv
hdl/psnt_if.sv
hdl/psnt_cell.sv
hdl/priority_sorted_name_table.sv
tb/tb.sv
